// ===== src/awd_pkg.sv =====
// Shared constants, register codes and inter-stage word types for the
// waveshaper pipeline. No dependencies.
package awd_pkg;

    // Sample format: signed Q1.23 in, signed Q5.23 out
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int OUT_BITS    = SAMPLE_BITS + 4;

    // Input gain is unsigned Q4.12
    localparam int GAIN_BITS = 16;
    localparam int GAIN_FRAC = 12;

    // Default depth of the exponential curve table
    localparam int EXP_TABLE_DEPTH = 256;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int MODE_BITS      = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHAPE_MODE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_GAIN = CFG_INDEX_BITS'(1);

    typedef enum logic [MODE_BITS-1:0] {
        SHAPE_HARD = 3'd0,
        SHAPE_SOFT = 3'd1,
        SHAPE_EXP  = 3'd2,
        SHAPE_HALF = 3'd3,
        SHAPE_FULL = 3'd4
    } t_shape_mode;

    localparam logic [MODE_BITS-1:0] SHAPE_MODE_RESET = SHAPE_FULL;
    localparam logic [GAIN_BITS-1:0] INPUT_GAIN_RESET = GAIN_BITS'(16306);

    // Output range limits
    localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // Word handed from the curve pipeline to the output selector
    typedef struct packed {
        logic [OUT_BITS-1:0]  g;         // gained sample, two's complement
        logic [OUT_BITS-1:0]  a;         // magnitude of g
        logic [FRAC_BITS-1:0] soft_mag;  // soft clip magnitude
        logic [FRAC_BITS:0]   exp_mag;   // exponential clip magnitude
    } t_shape_word;

endpackage

// ===== src/awd_gain.sv =====
// Input gain stage: multiply by Q4.12 gain, round, saturate to Q5.23.
// Two register stages. Depends on awd_pkg.
module awd_gain (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    output logic                               o_rdy,
    input  logic [awd_pkg::SAMPLE_BITS-1:0]    i_x,
    input  logic [awd_pkg::GAIN_BITS-1:0]      i_gain,
    output logic                               o_vld,
    input  logic                               i_rdy,
    output logic [awd_pkg::OUT_BITS-1:0]       o_g
);

    localparam int PROD_BITS = awd_pkg::SAMPLE_BITS + awd_pkg::GAIN_BITS + 1;
    localparam int RND_BITS  = PROD_BITS + 1;
    localparam int SHR_BITS  = RND_BITS - awd_pkg::GAIN_FRAC;
    localparam int OB        = awd_pkg::OUT_BITS;

    localparam logic signed [RND_BITS-1:0] ROUND_HALF =
        RND_BITS'(1) <<< (awd_pkg::GAIN_FRAC - 1);
    localparam logic signed [SHR_BITS-1:0] G_MAX = (SHR_BITS'(1) <<< (OB - 1)) - 1;
    localparam logic signed [SHR_BITS-1:0] G_MIN = -(SHR_BITS'(1) <<< (OB - 1));

    logic                        r_v1, r_v2;
    logic                        en1, en2;
    logic signed [PROD_BITS-1:0] n_prod, r_prod;
    logic signed [RND_BITS-1:0]  rnd;
    logic signed [SHR_BITS-1:0]  shr;
    logic [OB-1:0]               n_g, r_g;

    // Stage enables: a stage moves when empty or when the next one moves
    assign en2   = !r_v2 || i_rdy;
    assign en1   = !r_v1 || en2;
    assign o_rdy = en1;
    assign o_vld = r_v2;
    assign o_g   = r_g;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_vld;
            if (en2) r_v2 <= r_v1;
        end
    end

    // Multiply sample by gain
    assign n_prod = $signed(i_x) * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (en1 && i_vld) r_prod <= n_prod;
    end

    // Round to nearest (ties up), drop gain fraction, saturate
    always_comb begin
        rnd = RND_BITS'(r_prod) + ROUND_HALF;
        shr = SHR_BITS'(rnd >>> awd_pkg::GAIN_FRAC);
        if (shr > G_MAX) begin
            n_g = awd_pkg::OUT_MAX;
        end else if (shr < G_MIN) begin
            n_g = awd_pkg::OUT_MIN;
        end else begin
            n_g = shr[OB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) r_g <= n_g;
    end

    // Stalled output word holds until taken
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !i_rdy |=> r_v2 && $stable(r_g))
        else $error("gain stage word changed while stalled");

endmodule

// ===== src/awd_shape.sv =====
// Curve pipeline: magnitude, soft clip quadratic with divide by three,
// exponential table lookup with interpolation. Seven stages. Depends on awd_pkg.
module awd_shape #(
    parameter int EXP_TABLE_DEPTH = awd_pkg::EXP_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    output logic                          o_rdy,
    input  logic [awd_pkg::OUT_BITS-1:0]  i_g,
    output logic                          o_vld,
    input  logic                          i_rdy,
    output awd_pkg::t_shape_word          o_word
);

    localparam int F         = awd_pkg::FRAC_BITS;
    localparam int OB        = awd_pkg::OUT_BITS;
    localparam int EW        = F + 1;
    localparam int AW        = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int POS_BITS  = OB + AW;
    localparam int IDX_SHIFT = F + 4;
    localparam int FR_BITS   = 16;
    localparam int FR_SHIFT  = IDX_SHIFT - FR_BITS;
    localparam int IDX_BITS  = POS_BITS - IDX_SHIFT;
    localparam int A3_BITS   = OB + 2;
    localparam int DD_BITS   = 2 * F;
    localparam int SUM_BITS  = 2 * F + 1;
    localparam int PE_BITS   = EW + FR_BITS;
    localparam int RE_BITS   = PE_BITS + 1;
    localparam int STAGES    = 7;
    localparam int RSH       = 31 - F;

    localparam longint Q31_ONE = 64'sd1 <<< 31;

    localparam logic [AW-1:0]       DEPTH_A   = AW'(EXP_TABLE_DEPTH);
    localparam logic [IDX_BITS-1:0] DEPTH_I   = IDX_BITS'(EXP_TABLE_DEPTH);
    localparam logic [A3_BITS-1:0]  ONE_A3    = A3_BITS'(1) << F;
    localparam logic [A3_BITS-1:0]  TWO_A3    = A3_BITS'(1) << (F + 1);
    localparam logic [SUM_BITS-1:0] THREE_ONE = SUM_BITS'(3) << F;
    localparam logic [F-1:0]        RECIP3    = F'((64'sd1 <<< F) / 3);
    localparam logic [F-1:0]        HALF_F    = F'(1) << (F - 1);
    localparam logic [EW-1:0]       ONE_EW    = EW'(1) << F;
    localparam logic [RE_BITS-1:0]  RND_E     = RE_BITS'(1) << (FR_BITS - 1);

    typedef logic [EW-1:0] t_exp_rom [EXP_TABLE_DEPTH+1];

    typedef struct packed {
        logic [OB-1:0] g;
        logic [OB-1:0] a;
    } t_carry;

    // Long division of non-negative values, used only while building the table
    function automatic longint div_u63(longint num, longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            q = q <<< 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // exp(-f) in Q31 for f in [0,1], Taylor series
    function automatic longint exp_neg_q31(longint f);
        longint sum;
        longint term;
        int     k;
        sum  = Q31_ONE;
        term = Q31_ONE;
        k    = 1;
        while (k <= 30 && term != 0) begin
            term = div_u63((term * f) >>> 31, longint'(k));
            if (k % 2 == 1) sum = sum - term;
            else            sum = sum + term;
            k = k + 1;
        end
        if (sum < 0)       sum = 0;
        if (sum > Q31_ONE) sum = Q31_ONE;
        return sum;
    endfunction

    // Curve table 1-exp(-|x|) over |x| in [0,16], F fraction bits
    function automatic t_exp_rom exp_rom_build();
        t_exp_rom rom;
        longint   e1;
        longint   a;
        longint   n;
        longint   e;
        longint   d;
        e1 = exp_neg_q31(Q31_ONE);
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            a = div_u63(longint'(k) <<< 35, longint'(EXP_TABLE_DEPTH));
            n = a >>> 31;
            e = exp_neg_q31(a & (Q31_ONE - 1));
            for (longint i = 0; i < n; i++) begin
                e = (e * e1 + (64'sd1 <<< 30)) >>> 31;
            end
            d = Q31_ONE - e;
            if (RSH > 0) begin
                d = (d + (64'sd1 <<< (RSH - 1))) >>> RSH;
            end
            rom[k] = EW'(d);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = exp_rom_build();

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] up_vld;
    logic [STAGES-1:0] ld;

    // stage 1
    t_carry        n_c1, r_c1;
    // stage 2
    logic [POS_BITS-1:0] pos;
    logic [A3_BITS-1:0]  a3;
    logic [A3_BITS-1:0]  d_full;
    t_carry              r_c2;
    logic                r_lin2, r_top2;
    logic [F-1:0]        r_d2;
    logic [IDX_BITS-1:0] r_idx2;
    logic [FR_BITS-1:0]  r_fr2;
    // stage 3
    logic                sat;
    logic [AW-1:0]       addr_lo, addr_hi;
    logic [DD_BITS-1:0]  dd;
    t_carry              r_c3;
    logic                r_lin3, r_top3, r_sat3;
    logic [FR_BITS-1:0]  r_fr3;
    logic [DD_BITS-1:0]  r_dd3;
    logic [EW-1:0]       r_lo3, r_hi3;
    // stage 4
    logic [SUM_BITS-1:0] dd_sum;
    logic [EW-1:0]       n_diff;
    t_carry              r_c4;
    logic                r_lin4, r_top4;
    logic [FR_BITS-1:0]  r_fr4;
    logic [F-1:0]        r_v4;
    logic [EW-1:0]       r_lo4, r_diff4;
    // stage 5
    logic [DD_BITS-1:0]  vm;
    logic [PE_BITS-1:0]  pe;
    t_carry              r_c5;
    logic                r_lin5, r_top5;
    logic [F-1:0]        r_v5;
    logic [EW-1:0]       r_lo5;
    logic [DD_BITS-1:0]  r_vm5;
    logic [PE_BITS-1:0]  r_pe5;
    // stage 6
    logic [F-1:0]        q0;
    logic [F+1:0]        q3;
    logic [F+1:0]        rem_full;
    logic [RE_BITS-1:0]  pe_rnd;
    t_carry              r_c6;
    logic                r_lin6, r_top6;
    logic [F-1:0]        r_q06;
    logic [2:0]          r_rem6;
    logic [EW-1:0]       r_exp6;
    // stage 7
    logic                inc;
    logic [F-1:0]        n_soft;
    awd_pkg::t_shape_word r_word7;

    // Stage enables: each stage moves when empty or when the next one moves
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_rdy;
        for (int s = STAGES - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign up_vld = {r_vld[STAGES-2:0], i_vld};
    assign ld     = en & up_vld;
    assign o_rdy  = en[0];
    assign o_vld  = r_vld[STAGES-1];
    assign o_word = r_word7;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < STAGES; s++) begin
                if (en[s]) r_vld[s] <= up_vld[s];
            end
        end
    end

    // Stage 1: take magnitude
    always_comb begin
        n_c1.g = i_g;
        n_c1.a = i_g[OB-1] ? (~i_g + OB'(1)) : i_g;
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) r_c1 <= n_c1;
    end

    // Stage 2: table position, soft clip knees
    assign pos    = {{AW{1'b0}}, r_c1.a} * {{OB{1'b0}}, DEPTH_A};
    assign a3     = {2'b00, r_c1.a} + {1'b0, r_c1.a, 1'b0};
    assign d_full = TWO_A3 - a3;

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_c2   <= r_c1;
            r_lin2 <= a3 <= ONE_A3;
            r_top2 <= a3 > TWO_A3;
            r_d2   <= d_full[F-1:0];
            r_idx2 <= pos[POS_BITS-1:IDX_SHIFT];
            r_fr2  <= pos[IDX_SHIFT-1:FR_SHIFT];
        end
    end

    // Stage 3: table read, square the knee distance
    assign sat     = r_idx2 >= DEPTH_I;
    assign addr_lo = sat ? DEPTH_A : r_idx2[AW-1:0];
    assign addr_hi = sat ? DEPTH_A : AW'(addr_lo + AW'(1));
    assign dd      = {{F{1'b0}}, r_d2} * {{F{1'b0}}, r_d2};

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_c3   <= r_c2;
            r_lin3 <= r_lin2;
            r_top3 <= r_top2;
            r_sat3 <= sat;
            r_fr3  <= r_fr2;
            r_dd3  <= dd;
            r_lo3  <= EXP_ROM[addr_lo];
            r_hi3  <= EXP_ROM[addr_hi];
        end
    end

    // Stage 4: round and scale square, interpolation step
    assign dd_sum = {1'b0, r_dd3} + THREE_ONE;
    assign n_diff = (r_sat3 || r_hi3 < r_lo3) ? EW'(0) : EW'(r_hi3 - r_lo3);

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_c4    <= r_c3;
            r_lin4  <= r_lin3;
            r_top4  <= r_top3;
            r_fr4   <= r_fr3;
            r_v4    <= dd_sum[SUM_BITS-1:F+1];
            r_lo4   <= r_lo3;
            r_diff4 <= n_diff;
        end
    end

    // Stage 5: reciprocal multiply for divide by three, interpolation product
    assign vm = {{F{1'b0}}, r_v4} * {{F{1'b0}}, RECIP3};
    assign pe = {{FR_BITS{1'b0}}, r_diff4} * {{EW{1'b0}}, r_fr4};

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_c5   <= r_c4;
            r_lin5 <= r_lin4;
            r_top5 <= r_top4;
            r_v5   <= r_v4;
            r_lo5  <= r_lo4;
            r_vm5  <= vm;
            r_pe5  <= pe;
        end
    end

    // Stage 6: quotient estimate and remainder, finish interpolation
    assign q0       = r_vm5[DD_BITS-1:F];
    assign q3       = {2'b00, q0} + {1'b0, q0, 1'b0};
    assign rem_full = {2'b00, r_v5} - q3;
    assign pe_rnd   = {1'b0, r_pe5} + RND_E;

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_c6   <= r_c5;
            r_lin6 <= r_lin5;
            r_top6 <= r_top5;
            r_q06  <= q0;
            r_rem6 <= rem_full[2:0];
            r_exp6 <= r_lo5 + pe_rnd[PE_BITS-1:FR_BITS];
        end
    end

    // Stage 7: correct quotient, pick soft clip segment
    assign inc = r_rem6 >= 3'd3;

    always_comb begin
        if (r_lin6) begin
            n_soft = r_c6.a[F-1:0];
        end else if (r_top6) begin
            n_soft = HALF_F;
        end else begin
            n_soft = HALF_F - r_q06 - F'(inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r_word7.g        <= r_c6.g;
            r_word7.a        <= r_c6.a;
            r_word7.soft_mag <= n_soft;
            r_word7.exp_mag  <= r_exp6;
        end
    end

    // A stall seen upstream means every stage holds a word
    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rdy |-> &r_vld)
        else $error("curve pipeline stalled with an empty stage");

    // Interpolated curve never passes unity
    a_exp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> r_exp6 <= ONE_EW)
        else $error("exponential magnitude above one");

endmodule

// ===== src/awd_mix.sv =====
// Output stage: select the curve by mode, apply sign, hold the result word.
// One register stage. Depends on awd_pkg.
module awd_mix (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [awd_pkg::MODE_BITS-1:0]   i_mode,
    input  logic                            i_vld,
    output logic                            o_rdy,
    input  awd_pkg::t_shape_word            i_word,
    output logic                            o_vld,
    input  logic                            i_rdy,
    output logic [awd_pkg::OUT_BITS-1:0]    o_y
);

    localparam int OB = awd_pkg::OUT_BITS;
    localparam int F  = awd_pkg::FRAC_BITS;

    localparam logic signed [OB-1:0] HALF_S     = OB'(1) <<< (F - 1);
    localparam logic signed [OB-1:0] NEG_HALF_S = -(OB'(1) <<< (F - 1));

    logic                 en;
    logic                 r_vld;
    logic [OB-1:0]        r_y, n_y;
    logic signed [OB-1:0] g;
    logic                 neg;
    logic [OB-1:0]        soft_ext, exp_ext;

    assign en    = !r_vld || i_rdy;
    assign o_rdy = en;
    assign o_vld = r_vld;
    assign o_y   = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_vld;
        end
    end

    assign g        = $signed(i_word.g);
    assign neg      = i_word.g[OB-1];
    assign soft_ext = {{(OB-F){1'b0}}, i_word.soft_mag};
    assign exp_ext  = {{(OB-F-1){1'b0}}, i_word.exp_mag};

    // Pick the curve, restore sign
    always_comb begin
        case (i_mode)
            awd_pkg::SHAPE_HARD: begin
                if (g > HALF_S)          n_y = HALF_S;
                else if (g < NEG_HALF_S) n_y = NEG_HALF_S;
                else                     n_y = i_word.g;
            end
            awd_pkg::SHAPE_SOFT: begin
                n_y = neg ? (~soft_ext + OB'(1)) : soft_ext;
            end
            awd_pkg::SHAPE_EXP: begin
                n_y = neg ? (~exp_ext + OB'(1)) : exp_ext;
            end
            awd_pkg::SHAPE_HALF: begin
                n_y = (g > 0) ? i_word.g : '0;
            end
            default: begin
                n_y = (i_word.a > awd_pkg::OUT_MAX) ? awd_pkg::OUT_MAX : i_word.a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en && i_vld) r_y <= n_y;
    end

    // Hard clip stays within half scale
    a_hard_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && i_mode == awd_pkg::SHAPE_HARD
        |-> $signed(r_y) <= HALF_S && $signed(r_y) >= NEG_HALF_S)
        else $error("hard clip output out of range");

    // Rectifier modes never go negative
    a_rect_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && (i_mode == awd_pkg::SHAPE_HALF || i_mode == awd_pkg::SHAPE_FULL)
        |-> !r_y[OB-1])
        else $error("rectified output is negative");

endmodule

// ===== src/audio_waveshaper_distortion.sv =====
// Waveshaping distortion top level: configuration registers, gain stage,
// curve pipeline and output selector. Depends on awd_pkg, awd_gain, awd_shape, awd_mix.
//
//   channel     signals                                     width   dir
//   sample in   i_sample_in_valid / o_sample_in_ready        24 s    in
//   sample out  o_sample_out_valid / i_sample_out_ready      28 s    out
//   config      i_cfg_we, i_cfg_idx, i_cfg_data              1/16    in
//
// One word accepted per clock while the output is not stalled; stages: 2 gain, 7 curve, 1 output.
// The curve table is a constant ROM read at two addresses in one stage.
// Reset (synchronous, active low) empties the pipeline and loads full-wave mode
// and a gain of 16306. A stalled output fills the pipeline stage by stage;
// input ready drops only once every stage holds a word.
module audio_waveshaper_distortion #(
    parameter int EXP_TABLE_DEPTH = awd_pkg::EXP_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_sample_in_valid,
    output logic                                 o_sample_in_ready,
    input  logic [awd_pkg::SAMPLE_BITS-1:0]      i_sample_in,
    output logic                                 o_sample_out_valid,
    input  logic                                 i_sample_out_ready,
    output logic [awd_pkg::OUT_BITS-1:0]         o_sample_out,
    input  logic                                 i_cfg_we,
    input  logic [awd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_idx,
    input  logic [awd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [awd_pkg::MODE_BITS-1:0] r_shape_mode;
    logic [awd_pkg::GAIN_BITS-1:0] r_input_gain;

    logic                          gain_vld, gain_rdy;
    logic [awd_pkg::OUT_BITS-1:0]  gain_g;
    logic                          shape_vld, shape_rdy;
    awd_pkg::t_shape_word          shape_word;

    // Write configuration registers; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_mode <= awd_pkg::SHAPE_MODE_RESET;
            r_input_gain <= awd_pkg::INPUT_GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                awd_pkg::CFG_SHAPE_MODE: r_shape_mode <= i_cfg_data[awd_pkg::MODE_BITS-1:0];
                awd_pkg::CFG_INPUT_GAIN: r_input_gain <= i_cfg_data[awd_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    awd_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_sample_in_valid),
        .o_rdy   (o_sample_in_ready),
        .i_x     (i_sample_in),
        .i_gain  (r_input_gain),
        .o_vld   (gain_vld),
        .i_rdy   (gain_rdy),
        .o_g     (gain_g)
    );

    awd_shape #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (gain_vld),
        .o_rdy   (gain_rdy),
        .i_g     (gain_g),
        .o_vld   (shape_vld),
        .i_rdy   (shape_rdy),
        .o_word  (shape_word)
    );

    awd_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_shape_mode),
        .i_vld   (shape_vld),
        .o_rdy   (shape_rdy),
        .i_word  (shape_word),
        .o_vld   (o_sample_out_valid),
        .i_rdy   (i_sample_out_ready),
        .o_y     (o_sample_out)
    );

endmodule

// ===== tb/sv/audio_waveshaper_distortion_chk.sv =====
// Checker for the waveshaper: watches the sample channels and the config port,
// predicts each shaped word and compares it. Depends on awd_pkg.
module audio_waveshaper_distortion_chk
    import awd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_sample_in_valid,
    input  logic                      i_sample_in_ready,
    input  logic [SAMPLE_BITS-1:0]    i_sample_in,
    input  logic                      i_sample_out_valid,
    input  logic                      i_sample_out_ready,
    input  logic [OUT_BITS-1:0]       i_sample_out,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q31_UNIT = 64'sd1 <<< 31;

    // Shadow copy of the block's registers
    logic [MODE_BITS-1:0] mode_q;
    logic [GAIN_BITS-1:0] gain_q;

    // 1 - exp(-|x|) over [0,16], FRAC_BITS fraction bits
    longint curve_tab [0:EXP_TABLE_DEPTH];

    // Shaped words still owed by the block, oldest first
    logic [OUT_BITS-1:0] shaped_queue [$];

    // exp(-f) in Q31 for f in [0,1], by Taylor series
    function automatic longint exp_neg_q31(longint f);
        longint sum;
        longint term;
        sum  = Q31_UNIT;
        term = Q31_UNIT;
        for (int k = 1; k <= 30 && term != 0; k++) begin
            term = ((term * f) >>> 31) / k;
            if (k % 2 == 1) sum = sum - term;
            else            sum = sum + term;
        end
        if (sum < 0)        sum = 0;
        if (sum > Q31_UNIT) sum = Q31_UNIT;
        return sum;
    endfunction

    // Build the curve table: fraction part by series, integer part by powers of exp(-1)
    initial begin : build_curve
        longint e1;
        longint arg;
        longint whole;
        longint e;
        longint d;
        e1 = exp_neg_q31(Q31_UNIT);
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            arg   = (longint'(k) <<< 35) / EXP_TABLE_DEPTH;
            whole = arg >>> 31;
            e     = exp_neg_q31(arg & (Q31_UNIT - 1));
            for (longint i = 0; i < whole; i++)
                e = (e * e1 + (64'sd1 <<< 30)) >>> 31;
            d = Q31_UNIT - e;
            d = (d + (64'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
            curve_tab[k] = d;
        end
    end

    // Gain, round, saturate, then apply the selected transfer curve
    function automatic logic [OUT_BITS-1:0] shape_sample(logic [SAMPLE_BITS-1:0] raw,
                                                         logic [MODE_BITS-1:0] mode,
                                                         logic [GAIN_BITS-1:0] gain);
        longint one;
        longint half;
        longint omax;
        longint omin;
        longint x;
        longint g;
        longint a;
        longint y;
        longint d;
        longint pos;
        longint idx;
        longint fr;
        longint diff;
        bit     neg;
        one  = 64'sd1 <<< FRAC_BITS;
        half = one >>> 1;
        omax = (64'sd1 <<< (OUT_BITS - 1)) - 1;
        omin = -(64'sd1 <<< (OUT_BITS - 1));
        x    = longint'(signed'(raw));
        g    = (x * longint'(gain) + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        if (g > omax) g = omax;
        if (g < omin) g = omin;
        neg = (g < 0);
        a   = neg ? -g : g;
        case (mode)
            SHAPE_HARD: begin
                y = (g > half) ? half : ((g < -half) ? -half : g);
            end
            SHAPE_SOFT: begin
                if (3 * a <= one) begin
                    y = a;
                end else if (3 * a > 2 * one) begin
                    y = half;
                end else begin
                    d = 2 * one - 3 * a;
                    y = half - (d * d + 3 * one) / (6 * one);
                end
                if (neg) y = -y;
            end
            SHAPE_EXP: begin
                pos = a * EXP_TABLE_DEPTH;
                idx = pos >>> (FRAC_BITS + 4);
                fr  = (pos >>> (FRAC_BITS - 12)) & 64'hFFFF;
                if (idx >= EXP_TABLE_DEPTH) begin
                    y = curve_tab[EXP_TABLE_DEPTH];
                end else begin
                    diff = curve_tab[idx + 1] - curve_tab[idx];
                    if (diff < 0) diff = 0;
                    y = curve_tab[idx] + ((diff * fr + 64'sh8000) >>> 16);
                end
                if (neg) y = -y;
            end
            SHAPE_HALF: begin
                y = (g > 0) ? g : 0;
            end
            // full-wave, and the unused codes behave the same
            default: begin
                y = (a > omax) ? omax : a;
            end
        endcase
        return y[OUT_BITS-1:0];
    endfunction

    // Track config, queue predictions on input words, compare output words
    always @(posedge i_clk) begin : watch
        logic [OUT_BITS-1:0] want;
        if (!i_rst_n) begin
            mode_q       <= SHAPE_MODE_RESET;
            gain_q       <= INPUT_GAIN_RESET;
            shaped_queue.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SHAPE_MODE)
                    mode_q <= i_cfg_data[MODE_BITS-1:0];
                else if (i_cfg_idx == CFG_INPUT_GAIN)
                    gain_q <= i_cfg_data[GAIN_BITS-1:0];
            end
            if (i_sample_in_valid && i_sample_in_ready)
                shaped_queue.push_back(shape_sample(i_sample_in, mode_q, gain_q));
            if (i_sample_out_valid && i_sample_out_ready) begin
                if (shaped_queue.size() == 0) begin
                    $error("sample_out: expected none, actual %0d", $signed(i_sample_out));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = shaped_queue.pop_front();
                    if (want !== i_sample_out) begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(want), $signed(i_sample_out));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= shaped_queue.size();
        end
    end

endmodule

// ===== tb/sv/audio_waveshaper_distortion_tb.sv =====
// Testbench top for the waveshaper: clock, reset, config writes and sample
// stimulus with random idling. Depends on awd_pkg, audio_waveshaper_distortion, audio_waveshaper_distortion_chk.
module audio_waveshaper_distortion_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import awd_pkg::*;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int DRAIN_CYCLES      = 12;
    localparam int SETTINGS_PER_PASS = 4;
    localparam int WORDS_PER_SETTING = 167;

    logic                      clk              = 1'b0;
    logic                      rst_n            = 1'b0;
    logic                      sample_in_valid  = 1'b0;
    logic                      sample_in_ready;
    logic [SAMPLE_BITS-1:0]    sample_in        = '0;
    logic                      sample_out_valid;
    logic                      sample_out_ready = 1'b0;
    logic [OUT_BITS-1:0]       sample_out;
    logic                      cfg_we           = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_idx          = CFG_SHAPE_MODE;
    logic [CFG_DATA_BITS-1:0]  cfg_data         = '0;

    int fail_count;
    int pending;
    int send_idle   = 0;
    int recv_idle   = 0;
    int cycle_count = 0;

    // Edge values and curve knees
    logic [SAMPLE_BITS-1:0] edge_pts [5] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                            24'hFFFFFF, 24'h000001};
    logic [SAMPLE_BITS-1:0] hard_pts [5] = '{24'h7FFFFF, 24'h800000, 24'h400000,
                                            24'h400001, 24'hBFFFFF};
    logic [SAMPLE_BITS-1:0] soft_pts [5] = '{24'h2AAAAA, 24'h2AAAAB, 24'hAAAAAB,
                                            24'h555556, 24'hFFFFFF};

    audio_waveshaper_distortion u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_sample_in_valid  (sample_in_valid),
        .o_sample_in_ready  (sample_in_ready),
        .i_sample_in        (sample_in),
        .o_sample_out_valid (sample_out_valid),
        .i_sample_out_ready (sample_out_ready),
        .o_sample_out       (sample_out),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data)
    );

    audio_waveshaper_distortion_chk u_chk (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_sample_in_valid  (sample_in_valid),
        .i_sample_in_ready  (sample_in_ready),
        .i_sample_in        (sample_in),
        .i_sample_out_valid (sample_out_valid),
        .i_sample_out_ready (sample_out_ready),
        .i_sample_out       (sample_out),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the output side at random
    always @(negedge clk) begin
        sample_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Give up well past the slowest correct run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one word, idling first at random; enter and leave on a falling edge
    task automatic send_word(input logic [SAMPLE_BITS-1:0] s);
        while ($urandom_range(99) < send_idle) begin
            sample_in_valid <= 1'b0;
            @(negedge clk);
        end
        sample_in_valid <= 1'b1;
        sample_in       <= s;
        do @(posedge clk); while (!sample_in_ready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every shaped word has come back and the pipe drained
    task automatic wait_idle();
        sample_in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write both registers back to back; upper mode bits carry noise
    task automatic write_config(input logic [MODE_BITS-1:0] mode,
                                input logic [GAIN_BITS-1:0] gain);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SHAPE_MODE;
        cfg_data <= {CFG_DATA_BITS'($urandom_range(8191)) << MODE_BITS} | mode;
        @(negedge clk);
        cfg_idx  <= CFG_INPUT_GAIN;
        cfg_data <= gain;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mix of full-range, edge and scaled-down words
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(3))
            0: v = edge_pts[$urandom_range(4)];
            1: begin
                v = SAMPLE_BITS'($urandom) >> $urandom_range(SAMPLE_BITS - 1);
                if ($urandom_range(1) == 1) v = -v;
            end
            default: v = SAMPLE_BITS'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain(input int setting);
        case (setting % 6)
            0:       return 16'hFFFF;
            2:       return 16'd4096;
            4:       return 16'd0;
            default: return GAIN_BITS'($urandom_range(65535));
        endcase
    endfunction

    initial begin
        // Hold reset low at start, release on a falling edge
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: full-wave at the default gain
        send_word(24'h800000);
        send_word(24'h7FFFFF);

        // Hard clip at unity gain around the clip level
        write_config(SHAPE_HARD, 16'd4096);
        foreach (hard_pts[i]) send_word(hard_pts[i]);

        // Soft clip at unity gain around both knees
        write_config(SHAPE_SOFT, 16'd4096);
        foreach (soft_pts[i]) send_word(soft_pts[i]);

        // Exponential at full gain
        write_config(SHAPE_EXP, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_word(edge_pts[i]);

        // Half-wave at the default gain
        write_config(SHAPE_HALF, INPUT_GAIN_RESET);
        send_word(24'h000001);
        send_word(24'hFFFFFF);
        send_word(24'h000000);
        send_word(24'h7FFFFF);

        // Full-wave at full gain, then an unused code at zero gain
        write_config(SHAPE_FULL, 16'hFFFF);
        send_word(24'h800000);
        send_word(24'h7FFFFF);
        send_word(24'hFFFFFF);
        write_config(3'd7, 16'd0);
        send_word(24'h800000);

        // Random words over three idling passes, several settings each
        for (int pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    send_idle = 24;
                    recv_idle = 68;
                end
                1: begin
                    send_idle = 68;
                    recv_idle = 24;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int s = 0; s < SETTINGS_PER_PASS; s++) begin
                write_config(MODE_BITS'((pass * SETTINGS_PER_PASS + s) % 8),
                             pick_gain(pass * SETTINGS_PER_PASS + s));
                repeat (WORDS_PER_SETTING) send_word(random_sample());
            end
        end

        // Drain and report
        wait_idle();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
